// ===== sv/ssms_pkg.sv =====
// Shared types and constants for the split mean / standard deviation block.
// No dependencies.
`default_nettype none
package ssms_pkg;
  localparam int SampleBits = 24;
  localparam int MaxSamples = 65536;
  localparam int AddrBits   = $clog2(MaxSamples);
  localparam int CntBits    = AddrBits + 1;
  localparam int SumBits    = SampleBits + CntBits;
  localparam int SqBits     = 64;
  // nine result fields of SampleBits (one of them a bit short) and two flags
  localparam int FieldBits  = 9 * SampleBits + 1;
  localparam int OutBytes   = (FieldBits + 7) / 8;
  localparam int OutBits    = OutBytes * 8;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic signed [SumBits-1:0] sum_t;

  // Division request and reply between the top level and the divider.
  typedef struct packed {
    logic          start;
    logic          neg;
    logic [SqBits-1:0] num;
    logic [CntBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SqBits-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/ssms_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ssms_pkg.
`default_nettype none
module ssms_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ssms_pkg::div_req_t req,
  output ssms_pkg::div_rsp_t      rsp
);
  import ssms_pkg::*;
  logic [SqBits-1:0]  q;
  logic [CntBits-1:0] r;
  logic [CntBits-1:0] d;
  logic [6:0]         n;
  logic               busy, neg, done;
  logic [CntBits:0]   rs;

  assign rs = {r, q[SqBits-1]};

  // Apply the sign once the magnitude quotient is complete
  assign rsp = {done, neg ? (~q + SqBits'(1)) : q};

  // Shift in one numerator bit a cycle and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q <= req.num;
        r <= '0;
        d <= req.den;
        neg <= req.neg;
        n <= 7'd0;
      end else if (busy) begin
        if (rs >= {1'b0, d}) begin
          r <= CntBits'(rs - {1'b0, d});
          q <= {q[SqBits-2:0], 1'b1};
        end else begin
          r <= rs[CntBits-1:0];
          q <= {q[SqBits-2:0], 1'b0};
        end
        n <= n + 7'd1;
        if (n == 7'(SqBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/signed_split_mean_stddev.sv =====
// Split mean / standard deviation over a run of signed Q8.16 samples.
// s_axis: tdata = sample[23:0], tlast = end of run. One sample per cycle
// while loading; each is written to a 64K-entry sample memory and folded
// into running counts, sums, minimum and maximum.
// After the transaction with tlast, s_axis_tready drops. The block runs four
// divisions for the means on one shared bit-serial divider, sweeps the
// memory once (one registered read a cycle), then per group divides the
// squared sum and takes a bit-serial square root. m_axis carries one
// transaction per run; while the receiver stalls the result is held and no
// new sample is taken. s_axis_tready returns the cycle after the result is
// taken. Samples beyond 65536 in a run are dropped but their tlast still
// ends the run. m_axis tdata, low to high: mean_all[23:0], mean_abs[23:0],
// negative mean[23:0], non-negative mean[22:0], sd_all, sd_neg, sd_pos,
// range_min, range_max (24 each), neg_empty, pos_empty, zero pad. Reset
// clears the run counts, sums, minimum, maximum and control state; memory
// contents are left as they are and need no clearing.
// Depends on ssms_pkg and ssms_div.
`default_nettype none
module signed_split_mean_stddev (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [ssms_pkg::SampleBits-1:0] s_axis_tdata,   // sample
  input  wire logic                            s_axis_tlast,   // last
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [ssms_pkg::OutBits-1:0]         m_axis_tdata    // see header for field order
);
  import ssms_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD = 6'b00_0001, S_DIV  = 6'b00_0010, S_SWEEP = 6'b00_0100,
    S_SDIV = 6'b00_1000, S_SQRT = 6'b01_0000, S_OUT   = 6'b10_0000
  } state_t;

  state_t state;
  sample_t mem [MaxSamples];
  sample_t rd;
  logic [AddrBits-1:0] raddr;
  cnt_t tot, ncnt, pcnt, sweep;
  sum_t tsum, nsum, psum, asum;
  sample_t rmin, rmax;
  logic [SqBits-1:0] sq_all, sq_neg, sq_pos;
  logic signed [SampleBits:0] m_all, m_neg, m_pos;
  logic [SampleBits-1:0] m_abs;
  logic [SampleBits-1:0] sd_all, sd_neg, sd_pos;
  logic [1:0] step;
  logic rd_valid, div_issued, grp_empty, take;
  logic signed [SampleBits:0] vx, sx, dev_all, dev_grp;
  logic [SampleBits-1:0] mag_all, mag_grp;
  logic [2*SampleBits-1:0] sqv_all, sqv_grp;
  logic [2*SampleBits-1:0] rem, root, sq_bit, trial, root_nx;
  div_req_t dreq;
  div_rsp_t drsp;

  assign sx = {s_axis_tdata[SampleBits-1], s_axis_tdata};
  assign s_axis_tready = (state == S_LOAD);
  assign pcnt = tot - ncnt;

  ssms_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Sample memory: one write port in load, one registered read in sweep
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready && tot != cnt_t'(MaxSamples))
      mem[tot[AddrBits-1:0]] <= s_axis_tdata;
    rd <= mem[raddr];
  end

  // Squared deviations of the sample read last cycle, overall and in its group
  always_comb begin
    vx = {rd[SampleBits-1], rd};
    dev_all = vx - m_all;
    dev_grp = vx - (rd[SampleBits-1] ? m_neg : m_pos);
    mag_all = dev_all[SampleBits] ? SampleBits'(-dev_all) : dev_all[SampleBits-1:0];
    mag_grp = dev_grp[SampleBits] ? SampleBits'(-dev_grp) : dev_grp[SampleBits-1:0];
    sqv_all = mag_all * mag_all;
    sqv_grp = mag_grp * mag_grp;
  end

  // One square-root step: try the current bit against the remainder
  always_comb begin
    trial = root + sq_bit;
    take = (rem >= trial);
    root_nx = take ? ((root >> 1) + sq_bit) : (root >> 1);
  end

  // Flag whether the group whose deviation is being finished is empty
  always_comb begin
    case (step)
      2'd0: grp_empty = (tot == '0);
      2'd1: grp_empty = (ncnt == '0);
      default: grp_empty = (pcnt == '0);
    endcase
  end

  // Select divider operands for each division step; start once per division
  always_comb begin
    dreq = '0;
    dreq.start = (state == S_DIV || state == S_SDIV) && !div_issued;
    case (state)
      S_DIV: begin
        case (step)
          2'd0: begin
            dreq.neg = tsum[SumBits-1];
            dreq.num = SqBits'(tsum[SumBits-1] ? -tsum : tsum);
            dreq.den = tot;
          end
          2'd1: begin
            dreq.num = SqBits'(asum);
            dreq.den = tot;
          end
          2'd2: begin
            dreq.neg = 1'b1;
            dreq.num = SqBits'(-nsum);
            dreq.den = ncnt;
          end
          default: begin
            dreq.num = SqBits'(psum);
            dreq.den = pcnt;
          end
        endcase
      end
      S_SDIV: begin
        case (step)
          2'd0: begin dreq.num = sq_all; dreq.den = tot; end
          2'd1: begin dreq.num = sq_neg; dreq.den = ncnt; end
          default: begin dreq.num = sq_pos; dreq.den = pcnt; end
        endcase
      end
      default: ;
    endcase
  end

  // Run control, accumulation, sweep and square-root sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      tot <= '0; ncnt <= '0;
      tsum <= '0; nsum <= '0; psum <= '0; asum <= '0;
      rmin <= {1'b0, {(SampleBits-1){1'b1}}};
      rmax <= {1'b1, {(SampleBits-1){1'b0}}};
      m_axis_tvalid <= 1'b0;
      step <= '0; rd_valid <= 1'b0; div_issued <= 1'b0;
    end else begin
      // track the one division in flight
      if (dreq.start) div_issued <= 1'b1;
      else if (drsp.done) div_issued <= 1'b0;
      case (state)
        S_LOAD: begin
          if (s_axis_tvalid) begin
            if (tot != cnt_t'(MaxSamples)) begin
              tot <= tot + cnt_t'(1);
              tsum <= tsum + SumBits'(sx);
              if (sx < 0) begin
                ncnt <= ncnt + cnt_t'(1);
                nsum <= nsum + SumBits'(sx);
                asum <= asum - SumBits'(sx);
              end else begin
                psum <= psum + SumBits'(sx);
                asum <= asum + SumBits'(sx);
              end
              if ($signed(s_axis_tdata) < rmin) rmin <= s_axis_tdata;
              if ($signed(s_axis_tdata) > rmax) rmax <= s_axis_tdata;
            end
            if (s_axis_tlast) begin
              state <= S_DIV;
              step <= '0;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            case (step)
              2'd0: m_all <= (SampleBits+1)'(drsp.quo);
              2'd1: m_abs <= SampleBits'(drsp.quo);
              2'd2: m_neg <= (ncnt == '0) ? '0 : (SampleBits+1)'(drsp.quo);
              default: m_pos <= (pcnt == '0) ? '0 : (SampleBits+1)'(drsp.quo);
            endcase
            step <= step + 2'd1;
            if (step == 2'd3) begin
              state <= S_SWEEP;
              sweep <= '0; raddr <= '0;
              sq_all <= '0; sq_neg <= '0; sq_pos <= '0;
            end
          end
        end
        S_SWEEP: begin
          // advance read address; accumulate the entry read last cycle
          if (sweep != tot) begin
            sweep <= sweep + cnt_t'(1);
            raddr <= raddr + AddrBits'(1);
          end
          rd_valid <= (sweep != tot);
          if (rd_valid) begin
            sq_all <= sq_all + SqBits'(sqv_all);
            if (rd[SampleBits-1]) sq_neg <= sq_neg + SqBits'(sqv_grp);
            else sq_pos <= sq_pos + SqBits'(sqv_grp);
          end
          if (!rd_valid && sweep == tot) begin
            state <= S_SDIV; step <= '0;
          end
        end
        S_SDIV: begin
          // variance is below 2^(2*SampleBits); load the root search
          if (drsp.done) begin
            rem <= drsp.quo[2*SampleBits-1:0];
            root <= '0;
            sq_bit <= {2'b01, {(2*SampleBits-2){1'b0}}};
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // one result bit per cycle, top pair first
          if (take) rem <= rem - trial;
          root <= root_nx;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            case (step)
              2'd0: sd_all <= grp_empty ? '0 : root_nx[SampleBits-1:0];
              2'd1: sd_neg <= grp_empty ? '0 : root_nx[SampleBits-1:0];
              default: sd_pos <= grp_empty ? '0 : root_nx[SampleBits-1:0];
            endcase
            step <= step + 2'd1;
            state <= (step == 2'd2) ? S_OUT : S_SDIV;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {
              {(OutBits-FieldBits){1'b0}},
              (pcnt == '0), (ncnt == '0),
              rmax, rmin, sd_pos, sd_neg, sd_all,
              m_pos[SampleBits-2:0], m_neg[SampleBits-1:0], m_abs,
              m_all[SampleBits-1:0]};
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_LOAD;
            tot <= '0; ncnt <= '0;
            tsum <= '0; nsum <= '0; psum <= '0; asum <= '0;
            rmin <= {1'b0, {(SampleBits-1){1'b1}}};
            rmax <= {1'b1, {(SampleBits-1){1'b0}}};
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/ssms_check.sv =====
// Port-level checks for the split mean / standard deviation block.
// Depends on ssms_pkg and signed_split_mean_stddev; bound to it below.
`default_nettype none
module ssms_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         s_axis_tlast,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [ssms_pkg::OutBits-1:0] m_axis_tdata
);
  import ssms_pkg::*;
  // no sample is taken while a result waits
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
  // the end of a run closes the input
  a_close: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open after last");
  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OutBits-1:FieldBits] == '0) else $error("pad set");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
endmodule

bind signed_split_mean_stddev ssms_check u_ssms_check (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));
`default_nettype wire
